[rtl/core/distance_vector_route_table_macros.svh]
// Assertion macros shared by the route table RTL.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DVRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define DVRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DVRT_ASSERT(lbl, prop, msg)
`define DVRT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/dvrt_pkg.sv]
// Shared constants, codes and widths of the distance-vector route table.
package dvrt_pkg;

  localparam int NODES      = 8;
  localparam int FIELD_W    = 3;
  localparam int COST_W     = 16;
  localparam int ENTRIES    = NODES * NODES;
  localparam int ADDR_W     = $clog2(ENTRIES);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [COST_W-1:0] UNREACHABLE = '1;

  // Request opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  localparam logic [FIELD_W-1:0] SELF_RESET  = 3'd1;
  localparam logic [FIELD_W-1:0] COUNT_RESET = 3'd7;

endpackage

[rtl/core/dvrt_ram.sv]
// Generic RAM: one write port, two read ports with enable and registered data.
module dvrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two words, hold data while the enable is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[rtl/core/distance_vector_route_table.sv]
// Top level of the distance-vector route table: cost memory and route scan.
//
// Usage: requests enter on the in_* channel (valid/stall). A write request
// (op 0) stores new_cost at [row][col] and returns nothing.
// A compute request (op 1) returns node_count results on the out_* channel,
// one per destination 1..node_count, the last flagged by last_o.
// A compute checks one candidate per cycle while the output is not blocked:
// the scan issues one pair of table reads (self row entry, candidate row
// entry) per cycle to the two-read-port cost memory, and the candidate sum
// is compared when the registered read data arrives.
// in_stall_o is high while the scan issues reads; a new request is taken
// while the final result still waits in the output register.
// When a finished result meets a stalled full output register, the scan
// holds in place, read data frozen, and resumes when the result is taken.
// Reset restores self_index 1 and node_count 7 and clears the per-entry
// written flags at once, so the table reads as zero on the diagonal and
// unreachable elsewhere, with no clearing pass.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered.
`include "distance_vector_route_table_macros.svh"

module distance_vector_route_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dvrt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [dvrt_pkg::FIELD_W-1:0]      row_i,
  input  logic [dvrt_pkg::FIELD_W-1:0]      col_i,
  input  logic [dvrt_pkg::COST_W-1:0]       new_cost_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dvrt_pkg::FIELD_W-1:0]      dest_o,
  output logic [dvrt_pkg::COST_W-1:0]       route_cost_o,
  output logic                              has_hop_o,
  output logic [dvrt_pkg::FIELD_W-1:0]      next_hop_o,
  output logic                              last_o
);

  import dvrt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  function automatic logic [ADDR_W-1:0] cost_addr(input logic [FIELD_W-1:0] r,
                                                  input logic [FIELD_W-1:0] c);
    cost_addr = ADDR_W'(r) * ADDR_W'(NODES) + ADDR_W'(c);
  endfunction

  // Configuration
  logic [FIELD_W-1:0] self_index_q;
  logic [FIELD_W-1:0] node_count_q;
  logic [FIELD_W-1:0] count_eff;
  logic               self_oor;

  // Scan control
  state_e             state_q, state_d;
  logic [FIELD_W-1:0] j_q, j_d;
  logic [FIELD_W-1:0] d_q, d_d;
  logic               iss_valid_q, iss_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               move;
  logic               in_acc;

  // Issued read tags
  logic [FIELD_W-1:0] iss_j_q;
  logic [FIELD_W-1:0] iss_d_q;
  logic               iss_first_q;
  logic               iss_last_q;
  logic               iss_lastd_q;

  // Memory and written flags
  logic                  ram_we;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     addr_a;
  logic [ADDR_W-1:0]     addr_b;
  logic [COST_W-1:0]     rdata_a;
  logic [COST_W-1:0]     rdata_b;
  logic [ENTRIES-1:0]    written_q;
  logic                  vld_a_q;
  logic                  vld_b_q;

  // Accumulator
  logic [COST_W-1:0]  best_q;
  logic [FIELD_W-1:0] hop_q;
  logic               found_q;
  logic [COST_W-1:0]  base_best;
  logic [FIELD_W-1:0] base_hop;
  logic               base_found;
  logic [COST_W-1:0]  cost_a;
  logic [COST_W-1:0]  cost_b;
  logic [COST_W:0]    sum;
  logic               take;
  logic [COST_W-1:0]  new_best;
  logic [FIELD_W-1:0] new_hop;
  logic               new_found;

  // Output payload
  logic [FIELD_W-1:0] dest_q;
  logic [COST_W-1:0]  cost_q;
  logic               has_hop_q;
  logic [FIELD_W-1:0] hop_out_q;
  logic               last_q;

  assign count_eff = (int'(node_count_q) > NODES - 1) ? FIELD_W'(NODES - 1) : node_count_q;
  assign self_oor  = (int'(self_index_q) >= NODES);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_index_q <= SELF_RESET;
      node_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SELF_INDEX: self_index_q <= cfg_data_i;
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Hold the whole scan while a finished result cannot leave
  assign move = !(iss_valid_q && iss_last_q && out_valid_q && out_stall_i);

  // Table writes, out of range entries dropped
  assign ram_we = in_acc && (op_i == OP_WRITE) && (int'(row_i) < NODES) &&
                  (int'(col_i) < NODES);
  assign waddr  = cost_addr(row_i, col_i);
  assign addr_a = cost_addr(self_index_q, j_q);
  assign addr_b = cost_addr(j_q, d_q);

  dvrt_ram #(
    .WIDTH (COST_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr),
    .wdata_i   (new_cost_i),
    .re_i      (move),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Track written entries; unwritten ones read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (ram_we) begin
      written_q[waddr] <= 1'b1;
    end
  end

  // Sequence destinations and candidates
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    d_d         = d_q;
    iss_valid_d = iss_valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (move) begin
      iss_valid_d = (state_q == ST_SCAN);
      if (iss_valid_q && iss_last_q) begin
        out_valid_d = 1'b1;
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_i == OP_COMPUTE) && (count_eff != '0)) begin
          state_d = ST_SCAN;
          j_d     = FIELD_W'(1);
          d_d     = FIELD_W'(1);
        end
      end
      ST_SCAN: begin
        if (move) begin
          if (j_q == count_eff) begin
            j_d = FIELD_W'(1);
            if (d_q == count_eff) begin
              state_d = ST_IDLE;
            end else begin
              d_d = d_q + FIELD_W'(1);
            end
          end else begin
            j_d = j_q + FIELD_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= FIELD_W'(1);
      d_q         <= FIELD_W'(1);
      iss_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      d_q         <= d_d;
      iss_valid_q <= iss_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Compare one candidate against the running best
  always_comb begin
    base_best  = iss_first_q ? ((iss_d_q == self_index_q) ? '0 : UNREACHABLE) : best_q;
    base_hop   = iss_first_q ? '0 : hop_q;
    base_found = iss_first_q ? 1'b0 : found_q;
    if (self_oor) begin
      cost_a = UNREACHABLE;
    end else if (vld_a_q) begin
      cost_a = rdata_a;
    end else begin
      cost_a = (self_index_q == iss_j_q) ? '0 : UNREACHABLE;
    end
    if (vld_b_q) begin
      cost_b = rdata_b;
    end else begin
      cost_b = (iss_j_q == iss_d_q) ? '0 : UNREACHABLE;
    end
    sum       = {1'b0, cost_a} + {1'b0, cost_b};
    take      = (sum <= {1'b0, base_best});
    new_best  = take ? sum[COST_W-1:0] : base_best;
    new_hop   = take ? iss_j_q : base_hop;
    new_found = take || base_found;
  end

  // Advance tags, accumulator and output payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      vld_a_q <= written_q[addr_a];
      vld_b_q <= written_q[addr_b];
      if (state_q == ST_SCAN) begin
        iss_j_q     <= j_q;
        iss_d_q     <= d_q;
        iss_first_q <= (j_q == FIELD_W'(1));
        iss_last_q  <= (j_q == count_eff);
        iss_lastd_q <= (d_q == count_eff);
      end
      if (iss_valid_q) begin
        best_q  <= new_best;
        hop_q   <= new_hop;
        found_q <= new_found;
        if (iss_last_q) begin
          dest_q    <= iss_d_q;
          cost_q    <= new_best;
          has_hop_q <= new_found;
          hop_out_q <= new_hop;
          last_q    <= iss_lastd_q;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_o       = dest_q;
  assign route_cost_o = cost_q;
  assign has_hop_o    = has_hop_q;
  assign next_hop_o   = hop_out_q;
  assign last_o       = last_q;

  `DVRT_ASSERT(a_no_hop_zero, (out_valid_o && !has_hop_o) |-> (next_hop_o == '0), "result without hop reports a nonzero hop")
  `DVRT_ASSERT(a_hold_on_block, (iss_valid_q && !move) |=> (iss_valid_q && $stable(iss_j_q) && $stable(iss_d_q)), "scan moved while the output was blocked")
  `DVRT_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(iss_valid_q && iss_last_q), "result appeared without a finished destination")

endmodule

[tb/distance_vector_route_table_tb.sv]
// Self-checking testbench for the distance-vector route table.
module distance_vector_route_table_tb;
  import dvrt_pkg::*;

  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 80;   // covers a full 7-node scan
  localparam int QUIET_LIMIT   = 4000; // watchdog: cycles with no transfer
  localparam int RANDOM_PER_SETTING = 50;

  typedef struct packed {
    logic [FIELD_W-1:0] dest;
    logic [COST_W-1:0]  route_cost;
    logic               has_hop;
    logic [FIELD_W-1:0] next_hop;
    logic               last;
  } route_t;

  // Track the cost table and registers, predict route results and check them
  class route_scoreboard;
    logic [COST_W-1:0]  costs [NODES][NODES];
    logic [FIELD_W-1:0] self_idx;
    logic [FIELD_W-1:0] node_cnt;
    route_t             due_routes[$];
    int                 errors;
    int                 requests;
    int                 scans;
    int                 routes_checked;

    function new();
      foreach (costs[r, c]) costs[r][c] = (r == c) ? '0 : UNREACHABLE;
      self_idx = SELF_RESET;
      node_cnt = COUNT_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_SELF_INDEX) self_idx = val;
      else node_cnt = val;
    endfunction

    function int pending();
      return due_routes.size();
    endfunction

    // Apply a write, or scan every destination for a compute
    function void note_request(logic op, logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col,
                               logic [COST_W-1:0] cost);
      int                 cnt;
      logic [COST_W:0]    best;
      logic [COST_W:0]    sum;
      logic [FIELD_W-1:0] hop;
      logic               found;
      route_t             r;
      requests++;
      if (op == OP_WRITE) begin
        costs[row][col] = cost;
        return;
      end
      scans++;
      cnt = (int'(node_cnt) > NODES - 1) ? NODES - 1 : int'(node_cnt);
      for (int d = 1; d <= cnt; d++) begin
        best  = (d == int'(self_idx)) ? '0 : {1'b0, UNREACHABLE};
        hop   = '0;
        found = 1'b0;
        // Later candidates win ties; 17-bit sums above the cap never win
        for (int j = 1; j <= cnt; j++) begin
          sum = {1'b0, costs[self_idx][j]} + {1'b0, costs[j][d]};
          if (sum <= best) begin
            best  = sum;
            hop   = j[FIELD_W-1:0];
            found = 1'b1;
          end
        end
        r.dest       = d[FIELD_W-1:0];
        r.route_cost = best[COST_W-1:0];
        r.has_hop    = found;
        r.next_hop   = hop;
        r.last       = (d == cnt);
        due_routes.push_back(r);
      end
    endfunction

    // Compare one delivered route with the oldest prediction
    function void check_route(route_t got);
      route_t want;
      if (due_routes.size() == 0) begin
        $error("unexpected route result: dest %0d cost %0d", got.dest, got.route_cost);
        errors++;
        return;
      end
      want = due_routes.pop_front();
      routes_checked++;
      if (got.dest != want.dest) begin
        $error("dest: expected %0d, got %0d", want.dest, got.dest);
        errors++;
      end
      if (got.route_cost != want.route_cost) begin
        $error("route_cost: expected %0d, got %0d", want.route_cost, got.route_cost);
        errors++;
      end
      if (got.has_hop != want.has_hop) begin
        $error("has_hop: expected %0d, got %0d", want.has_hop, got.has_hop);
        errors++;
      end
      if (got.next_hop != want.next_hop) begin
        $error("next_hop: expected %0d, got %0d", want.next_hop, got.next_hop);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  op_i       = OP_WRITE;
  logic [FIELD_W-1:0]    row_i      = '0;
  logic [FIELD_W-1:0]    col_i      = '0;
  logic [COST_W-1:0]     new_cost_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [FIELD_W-1:0]    dest_o;
  logic [COST_W-1:0]     route_cost_o;
  logic                  has_hop_o;
  logic [FIELD_W-1:0]    next_hop_o;
  logic                  last_o;

  route_scoreboard sb = new();

  int  send_idle_pct = 26;
  int  recv_idle_pct = 47;
  bit  long_hold     = 1'b0;
  int  settings_used = 0;

  distance_vector_route_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .new_cost_i  (new_cost_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dest_o      (dest_o),
    .route_cost_o(route_cost_o),
    .has_hop_o   (has_hop_o),
    .next_hop_o  (next_hop_o),
    .last_o      (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sample both channels at the edge where a transfer happens
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(op_i, row_i, col_i, new_cost_i);
      if (out_valid_o && !out_stall_i)
        sb.check_route('{dest: dest_o, route_cost: route_cost_o, has_hop: has_hop_o,
                         next_hop: next_hop_o, last: last_o});
    end
  end

  // Stall the result channel at random; hold off for a long stretch on demand
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("** distance_vector_route_table: FAILED **");
    $finish;
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_request(logic op, logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col,
                              logic [COST_W-1:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= row;
    col_i      <= col;
    new_cost_i <= cost;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Request a route scan; the unused fields carry noise
  task automatic compute_routes();
    send_request(OP_COMPUTE, FIELD_W'($urandom_range(7)), FIELD_W'($urandom_range(7)),
                 COST_W'($urandom));
  endtask

  // Drop valid and wait until every predicted route has been delivered
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Mostly local-link and neighbor writes inside the active nodes, some scans
  task automatic random_traffic(int n);
    logic               op;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [COST_W-1:0]  cost;
    int                 cnt;
    repeat (n) begin
      cnt = int'(sb.node_cnt);
      op  = ($urandom_range(99) < 22) ? OP_COMPUTE : OP_WRITE;
      if ($urandom_range(9) < 4) row = sb.self_idx;
      else if (cnt > 0 && $urandom_range(9) < 8) row = FIELD_W'($urandom_range(cnt, 1));
      else row = FIELD_W'($urandom_range(7));
      if (cnt > 0 && $urandom_range(9) < 8) col = FIELD_W'($urandom_range(cnt, 1));
      else col = FIELD_W'($urandom_range(7));
      case ($urandom_range(9))
        0, 1, 2, 3: cost = COST_W'($urandom_range(15));
        4:          cost = '0;
        5:          cost = UNREACHABLE;
        6:          cost = COST_W'($urandom_range(16'hFFFF, 16'hFFF0));
        default:    cost = COST_W'($urandom);
      endcase
      send_request(op, row, col, cost);
    end
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0] self_plan  [9];
    logic [FIELD_W-1:0] count_plan [9];
    self_plan  = '{3'd3, 3'd7, 3'd0, 3'd5, 3'd2, 3'd1, 3'd6, 3'd4, 3'd1};
    count_plan = '{3'd7, 3'd7, 3'd5, 3'd1, 3'd0, 3'd4, 3'd7, 3'd3, 3'd7};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset table, ties, overflowing sums, row and column zero, extremes
    compute_routes();
    send_request(OP_WRITE, 3'd1, 3'd2, 16'd5);
    send_request(OP_WRITE, 3'd1, 3'd3, 16'd3);
    send_request(OP_WRITE, 3'd2, 3'd4, 16'd10);
    send_request(OP_WRITE, 3'd3, 3'd4, 16'd12);
    send_request(OP_WRITE, 3'd1, 3'd7, 16'hFFFE);
    send_request(OP_WRITE, 3'd7, 3'd5, 16'd2);
    send_request(OP_WRITE, 3'd0, 3'd0, UNREACHABLE);
    send_request(OP_WRITE, 3'd0, 3'd7, 16'd0);
    send_request(OP_WRITE, 3'd7, 3'd0, 16'h1234);
    send_request(OP_WRITE, 3'd7, 3'd7, UNREACHABLE);
    send_request(OP_WRITE, 3'd1, 3'd1, 16'h8000);
    send_request(OP_WRITE, 3'd1, 3'd6, 16'd0);
    send_request(OP_WRITE, 3'd6, 3'd2, 16'd0);
    compute_routes();
    send_request(OP_WRITE, 3'd1, 3'd1, 16'd0);
    send_request(OP_WRITE, 3'd4, 3'd5, 16'hAAAA);
    send_request(OP_WRITE, 3'd2, 3'd5, 16'h5555);
    send_request(OP_WRITE, 3'd1, 3'd4, UNREACHABLE);
    compute_routes();

    // Random: three idle profiles, each over three register settings
    for (int k = 0; k < 9; k++) begin
      if (k < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 47;
      end else if (k < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_reg(CFG_SELF_INDEX, self_plan[k]);
      set_reg(CFG_NODE_COUNT, count_plan[k]);
      settings_used++;
      compute_routes();
      if (k == 6) begin
        // Back up the block behind a long receiver hold-off, then pause until empty
        long_hold = 1'b1;
        repeat (12) compute_routes();
        wait_drained();
      end
      random_traffic(RANDOM_PER_SETTING);
    end

    wait_drained();
    $display("Run covered %0d requests with %0d route scans over %0d register settings,",
             sb.requests, sb.scans, settings_used);
    $display("checking %0d route results field by field.", sb.routes_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** distance_vector_route_table: PASSED **");
    end else begin
      $display("** distance_vector_route_table: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dvrt_pkg.sv
rtl/core/dvrt_ram.sv
rtl/core/distance_vector_route_table.sv
tb/distance_vector_route_table_tb.sv
